/* sv/tsni_pkg.sv */
package tsni_pkg;

   // largest payload that is parsed; a longer one gives not-found
   localparam logic [16:0] BUFFER_BYTES = 17'd16384;

   localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
   localparam logic [16:0] RANDOM_FIELD_BYTES = 17'd34;  // version and random
   localparam logic [15:0] OFFSET_MAX = 16'hFFFF;

   typedef logic [16:0] offset_type;
   typedef logic [24:0] wide_sum_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] payload_length;
      logic        payload_last;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] name_byte;
      logic       found;
      logic       result_last;
   } rsp_beat_type;

   typedef enum logic [19:0] {
      PH_TYPE      = 20'h00001,
      PH_HSLEN     = 20'h00002,
      PH_VERRND    = 20'h00004,
      PH_SIDLEN    = 20'h00008,
      PH_SID       = 20'h00010,
      PH_CSLEN     = 20'h00020,
      PH_CS        = 20'h00040,
      PH_CMLEN     = 20'h00080,
      PH_CM        = 20'h00100,
      PH_EXTLEN    = 20'h00200,
      PH_EXTTYPE   = 20'h00400,
      PH_EXTBLEN   = 20'h00800,
      PH_EXTSKIP   = 20'h01000,
      PH_LISTLEN   = 20'h02000,
      PH_NAMETYPE  = 20'h04000,
      PH_NLEN_HOST = 20'h08000,
      PH_NLEN_OTH  = 20'h10000,
      PH_NAMESKIP  = 20'h20000,
      PH_NAME      = 20'h40000,
      PH_DONE      = 20'h80000
   } phase_type;

   typedef enum logic [1:0] {
      EM_NONE = 2'd0,
      EM_BYTE = 2'd1,
      EM_LAST = 2'd2,
      EM_MISS = 2'd3
   } emit_type;

   typedef struct packed {
      logic       fail;
      phase_type  phase;
      offset_type field_end;
      logic       clr_acc;
   } enter_type;

endpackage

/* sv/tsni_req_if.sv */
interface tsni_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [15:0] payload_length;
   logic        payload_last;

   modport source (output valid, output data_byte, output payload_length,
                   output payload_last, input ready);
   modport sink (input valid, input data_byte, input payload_length,
                 input payload_last, output ready);
endinterface

/* sv/tsni_rsp_if.sv */
interface tsni_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] name_byte;
   logic       found;
   logic       result_last;

   modport source (output valid, output name_byte, output found,
                   output result_last, input ready);
   modport sink (input valid, input name_byte, input found,
                 input result_last, output ready);
endinterface

/* sv/tsni_parser.sv */
module tsni_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  beat_valid,
   input  tsni_pkg::req_beat_type req_beat,
   output logic                  result_valid,
   output tsni_pkg::rsp_beat_type result
);
   import tsni_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] offset_ff, offset_in;
   logic [23:0] acc_ff, acc_in;
   offset_type  field_end_ff, field_end_in;
   offset_type  ext_end_ff, ext_end_in;
   offset_type  nl_bound_ff, nl_bound_in;
   logic        is_sni_ff, is_sni_in;
   logic        given_ff, given_in;

   emit_type     emit;
   offset_type   nxt;
   logic [23:0]  acc_new;
   wide_sum_type nxt_sum, len_sum, ext_sum, list_sum;
   logic         go, fail;
   phase_type    go_phase;
   enter_type    ent;

   function automatic enter_type need_calc(phase_type ph, offset_type start,
                                           offset_type n, wide_sum_type limit);
      enter_type r;
      r.phase     = ph;
      r.field_end = start + n;
      r.clr_acc   = 1'b1;
      r.fail      = ({8'd0, start} + {8'd0, n}) > limit;
      return r;
   endfunction

   // phases that read a number field
   function automatic enter_type enter_count(phase_type ph, offset_type start,
                                             wide_sum_type cl, wide_sum_type ee,
                                             wide_sum_type ne);
      enter_type r;
      r = '{fail: 1'b1, phase: PH_DONE, field_end: start, clr_acc: 1'b0};
      case (ph)
         PH_HSLEN:     r = need_calc(ph, start, 17'd3, cl);
         PH_SIDLEN:    r = need_calc(ph, start, 17'd1, cl);
         PH_CSLEN:     r = need_calc(ph, start, 17'd2, cl);
         PH_CMLEN:     r = need_calc(ph, start, 17'd1, cl);
         PH_EXTLEN:    r = need_calc(ph, start, 17'd2, cl);
         PH_EXTTYPE: begin
            // whole type and length header must fit, only the type is read here
            r = need_calc(ph, start, 17'd4, ee);
            r.field_end = start + 17'd2;
         end
         PH_LISTLEN:   r = need_calc(ph, start, 17'd2, ee);
         PH_NAMETYPE:  r = need_calc(ph, start, 17'd1, ne);
         PH_NLEN_HOST: r = need_calc(ph, start, 17'd2, ne);
         PH_NLEN_OTH:  r = need_calc(ph, start, 17'd2, ne);
         default:      r.fail = 1'b1;
      endcase
      return r;
   endfunction

   function automatic enter_type enter_phase(phase_type ph, offset_type start,
                                             logic [23:0] acc, wide_sum_type cl,
                                             wide_sum_type ee, wide_sum_type ne);
      enter_type    r;
      logic         skip;
      wide_sum_type len;
      wide_sum_type lim;
      phase_type    fol;
      r    = '{fail: 1'b0, phase: ph, field_end: start, clr_acc: 1'b0};
      skip = 1'b0;
      len  = '0;
      lim  = '0;
      fol  = PH_NAMETYPE;
      case (ph)
         PH_EXTBLEN: begin
            r.field_end = start + 17'd2;
            r.clr_acc   = 1'b1;
         end
         PH_NAME:     r.field_end = start + acc[16:0];
         PH_VERRND: begin
            skip = 1'b1; len = {8'd0, RANDOM_FIELD_BYTES}; lim = cl; fol = PH_SIDLEN;
         end
         PH_SID: begin
            skip = 1'b1; len = {1'b0, acc}; lim = cl; fol = PH_CSLEN;
         end
         PH_CS: begin
            skip = 1'b1; len = {1'b0, acc}; lim = cl; fol = PH_CMLEN;
         end
         PH_CM: begin
            skip = 1'b1; len = {1'b0, acc}; lim = cl; fol = PH_EXTLEN;
         end
         PH_EXTSKIP: begin
            skip = 1'b1; len = {1'b0, acc}; lim = ee; fol = PH_EXTTYPE;
         end
         PH_NAMESKIP: begin
            skip = 1'b1; len = {1'b0, acc}; lim = ne; fol = PH_NAMETYPE;
         end
         default:     r = enter_count(ph, start, cl, ee, ne);
      endcase
      if (skip) begin
         if ({8'd0, start} + len > lim) begin
            r.fail = 1'b1;
         end else if (len == '0) begin
            // empty field: go straight on to the field that follows it
            r = enter_count(fol, start, cl, ee, ne);
         end else begin
            r.field_end = start + len[16:0];
         end
      end
      return r;
   endfunction

   function automatic phase_type skip_follow(phase_type ph);
      case (ph)
         PH_VERRND:  return PH_SIDLEN;
         PH_SID:     return PH_CSLEN;
         PH_CS:      return PH_CMLEN;
         PH_CM:      return PH_EXTLEN;
         PH_EXTSKIP: return PH_EXTTYPE;
         default:    return PH_NAMETYPE;
      endcase
   endfunction

   assign nxt      = {1'b0, offset_ff} + 17'd1;
   assign acc_new  = {acc_ff[15:0], req_beat.data_byte};
   assign nxt_sum  = {8'd0, nxt} + {1'b0, acc_new};
   assign len_sum  = {9'd0, req_beat.payload_length};
   assign ext_sum  = {8'd0, ext_end_in};
   assign list_sum = {8'd0, nl_bound_in};

   always_comb begin
      phase_in     = phase_ff;
      offset_in    = offset_ff;
      acc_in       = acc_ff;
      field_end_in = field_end_ff;
      ext_end_in   = ext_end_ff;
      nl_bound_in  = nl_bound_ff;
      is_sni_in    = is_sni_ff;
      given_in     = given_ff;
      emit         = EM_NONE;
      go           = 1'b0;
      go_phase     = PH_DONE;
      fail         = 1'b0;
      ent          = '{fail: 1'b0, phase: PH_DONE, field_end: '0, clr_acc: 1'b0};

      if (beat_valid && !given_ff) begin
         if ({1'b0, req_beat.payload_length} > BUFFER_BYTES) begin
            fail = 1'b1;
         end else begin
            case (phase_ff)
               PH_TYPE: begin
                  if (nxt > {1'b0, req_beat.payload_length} ||
                      req_beat.data_byte != HS_CLIENT_HELLO) begin
                     fail = 1'b1;
                  end else begin
                     go = 1'b1; go_phase = PH_HSLEN;
                  end
               end
               PH_VERRND, PH_SID, PH_CS, PH_CM, PH_EXTSKIP, PH_NAMESKIP: begin
                  if (nxt >= field_end_ff) begin
                     go = 1'b1; go_phase = skip_follow(phase_ff);
                  end
               end
               PH_NAME: begin
                  if (nxt >= field_end_ff) begin
                     emit = EM_LAST; given_in = 1'b1; phase_in = PH_DONE;
                  end else begin
                     emit = EM_BYTE;
                  end
               end
               PH_DONE: ;
               PH_HSLEN, PH_SIDLEN, PH_CSLEN, PH_CMLEN, PH_EXTLEN, PH_EXTTYPE,
               PH_EXTBLEN, PH_LISTLEN, PH_NAMETYPE, PH_NLEN_HOST, PH_NLEN_OTH: begin
                  acc_in = acc_new;
                  if (nxt >= field_end_ff) begin
                     case (phase_ff)
                        PH_HSLEN: begin
                           if (nxt_sum > len_sum) fail = 1'b1;
                           else begin go = 1'b1; go_phase = PH_VERRND; end
                        end
                        PH_SIDLEN: begin go = 1'b1; go_phase = PH_SID; end
                        PH_CSLEN:  begin go = 1'b1; go_phase = PH_CS; end
                        PH_CMLEN:  begin go = 1'b1; go_phase = PH_CM; end
                        PH_EXTLEN: begin
                           if (nxt_sum > len_sum) fail = 1'b1;
                           else begin
                              ext_end_in = nxt_sum[16:0];
                              go = 1'b1; go_phase = PH_EXTTYPE;
                           end
                        end
                        PH_EXTTYPE: begin
                           is_sni_in = (acc_new == '0);
                           go = 1'b1; go_phase = PH_EXTBLEN;
                        end
                        PH_EXTBLEN: begin
                           if (nxt_sum > {8'd0, ext_end_ff}) fail = 1'b1;
                           else begin
                              go = 1'b1;
                              go_phase = is_sni_ff ? PH_LISTLEN : PH_EXTSKIP;
                           end
                        end
                        PH_LISTLEN: begin
                           if (nxt_sum > {8'd0, ext_end_ff}) fail = 1'b1;
                           else begin
                              nl_bound_in = nxt_sum[16:0];
                              go = 1'b1; go_phase = PH_NAMETYPE;
                           end
                        end
                        PH_NAMETYPE: begin
                           go = 1'b1;
                           go_phase = (acc_new == '0) ? PH_NLEN_HOST : PH_NLEN_OTH;
                        end
                        PH_NLEN_OTH: begin go = 1'b1; go_phase = PH_NAMESKIP; end
                        PH_NLEN_HOST: begin
                           if (nxt_sum > {8'd0, nl_bound_ff} || acc_new == '0) fail = 1'b1;
                           else begin go = 1'b1; go_phase = PH_NAME; end
                        end
                        default: fail = 1'b1;
                     endcase
                  end
               end
               default: fail = 1'b1;
            endcase
         end

         if (go) begin
            ent = enter_phase(go_phase, nxt, acc_in, len_sum, ext_sum, list_sum);
            if (ent.fail) begin
               fail = 1'b1;
            end else begin
               phase_in     = ent.phase;
               field_end_in = ent.field_end;
               if (ent.clr_acc) acc_in = '0;
            end
         end

         if (fail) begin
            given_in = 1'b1;
            phase_in = PH_DONE;
            emit     = EM_MISS;
         end
      end

      if (beat_valid) begin
         if (req_beat.payload_last) begin
            if (!given_in) emit = EM_MISS;
            phase_in     = PH_TYPE;
            offset_in    = '0;
            acc_in       = '0;
            field_end_in = '0;
            ext_end_in   = '0;
            nl_bound_in  = '0;
            is_sni_in    = 1'b0;
            given_in     = 1'b0;
         end else if (offset_ff != OFFSET_MAX) begin
            offset_in = offset_ff + 16'd1;
         end
      end
   end

   assign result_valid       = beat_valid && (emit != EM_NONE);
   assign result.name_byte   = (emit == EM_MISS) ? 8'd0 : req_beat.data_byte;
   assign result.found       = (emit != EM_MISS);
   assign result.result_last = (emit != EM_BYTE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TYPE;
         offset_ff    <= '0;
         acc_ff       <= '0;
         field_end_ff <= '0;
         ext_end_ff   <= '0;
         nl_bound_ff  <= '0;
         is_sni_ff    <= 1'b0;
         given_ff     <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         offset_ff    <= offset_in;
         acc_ff       <= acc_in;
         field_end_ff <= field_end_in;
         ext_end_ff   <= ext_end_in;
         nl_bound_ff  <= nl_bound_in;
         is_sni_ff    <= is_sni_in;
         given_ff     <= given_in;
      end
   end

endmodule

/* sv/tsni_out_buf.sv */
module tsni_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  tsni_pkg::rsp_beat_type in_beat,
   output logic                  in_ready,
   output logic                  out_valid,
   output tsni_pkg::rsp_beat_type out_beat,
   input  logic                  out_ready
);
   import tsni_pkg::*;

   logic         out_valid_ff, out_valid_in;
   rsp_beat_type out_beat_ff, out_beat_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_beat_type skid_beat_ff, skid_beat_in;
   logic         in_fire;

   assign in_ready = !skid_valid_ff;
   assign in_fire  = in_valid && in_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_beat_in   = out_beat_ff;
      skid_valid_in = skid_valid_ff;
      skid_beat_in  = skid_beat_ff;
      if (!out_valid_ff || out_ready) begin
         // output slot frees up: older skid beat goes first
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_beat_in   = skid_beat_ff;
            skid_valid_in = in_fire;
            skid_beat_in  = in_beat;
         end else begin
            out_valid_in = in_fire;
            out_beat_in  = in_beat;
         end
      end else if (in_fire) begin
         skid_valid_in = 1'b1;
         skid_beat_in  = in_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_beat_ff  <= out_beat_in;
      skid_beat_ff <= skid_beat_in;
   end

   assign out_valid = out_valid_ff;
   assign out_beat  = out_beat_ff;

endmodule

/* sv/tls_sni_hostname_extractor_core.sv */
// channel  dir  beat fields                                  handshake
// req_if   in   data_byte, payload_length, payload_last      valid/ready
// rsp_if   out  name_byte, found, result_last                valid/ready
//
// one payload byte per cycle while req_if.ready is high; a result leaves in the cycle after its byte at the earliest
// parse state updates in the cycle a byte is taken, results pass a two-entry output buffer
// req_if.ready drops only while both output entries hold beats that are not yet taken
// synchronous active-high reset returns the parser to the handshake type byte
module tls_sni_hostname_extractor_core (
   input logic       clock,
   input logic       reset,
   tsni_req_if.sink   req_if,
   tsni_rsp_if.source rsp_if
);
   import tsni_pkg::*;

   req_beat_type req_beat;
   rsp_beat_type result, rsp_beat;
   logic         result_valid;
   logic         buf_ready;
   logic         req_fire;

   assign req_beat.data_byte      = req_if.data_byte;
   assign req_beat.payload_length = req_if.payload_length;
   assign req_beat.payload_last   = req_if.payload_last;

   assign req_if.ready = buf_ready;
   assign req_fire     = req_if.valid && buf_ready;

   tsni_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .beat_valid   (req_fire),
      .req_beat     (req_beat),
      .result_valid (result_valid),
      .result       (result)
   );

   tsni_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (result_valid),
      .in_beat   (result),
      .in_ready  (buf_ready),
      .out_valid (rsp_if.valid),
      .out_beat  (rsp_beat),
      .out_ready (rsp_if.ready)
   );

   assign rsp_if.name_byte   = rsp_beat.name_byte;
   assign rsp_if.found       = rsp_beat.found;
   assign rsp_if.result_last = rsp_beat.result_last;

endmodule
